// ----- hdl/lcsf_pkg.sv -----
package lcsf_pkg;

  localparam int CHAR_W = 8;
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] OBSTACLE_RESET = CHAR_W'(111);

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1,
    REG_OBSTACLE  = 2'd2
  } cfg_reg_t;

endpackage

// ----- hdl/lcsf_line_mem.sv -----
module lcsf_line_mem #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output lcsf_pkg::size_t rd_data_r,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  lcsf_pkg::size_t wr_data
);
  import lcsf_pkg::*;

  size_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/largest_clear_square_finder.sv -----
// Channel  Direction  Word                                   Handshake
// in       input      in_cell_char                           in_valid / in_stall
// out      output     out_square_size, out_top_row, out_left_col  out_valid / out_stall
// cfg      input      cfg_index, cfg_wdata                   cfg_we
//
// One cell word is taken per cycle while in_stall is low; each word passes a read
// stage and an update stage; updating a grid's last cell registers the result word.
// The line store has one read and one write port, so one column per cycle unless stalled.
// After reset a clearing pass zeroes all MAX_COLS line store entries; in_stall is high.
// in_stall also rises while a finished result waits and the next grid's last cell is ready.
module largest_clear_square_finder #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lcsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcsf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lcsf_pkg::char_t                in_cell_char,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lcsf_pkg::size_t                out_square_size,
  output lcsf_pkg::pos_t                 out_top_row,
  output lcsf_pkg::pos_t                 out_left_col
);
  import lcsf_pkg::*;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CCMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int RCMP_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             first_row;
    logic             first_col;
    logic             obst;
    logic             last;
  } s1_t;

  logic [CFG_W-1:0]  grid_rows_r, grid_cols_r;
  char_t             obstacle_r;
  logic [COL_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic              clearing_r;
  logic [COL_W-1:0]  clr_addr_r;
  logic              s1_valid_r, s1_valid_nxt;
  s1_t               s1_r;
  logic              fwd_r;
  size_t             fwd_data_r;
  size_t             left_r, diag_r;
  size_t             best_size_r, best_size_nxt;
  pos_t              best_row_r, best_row_nxt;
  pos_t              best_col_r, best_col_nxt;
  logic              out_valid_r;
  size_t             out_size_r;
  pos_t              out_row_r, out_col_r;

  logic [CCMP_W-1:0] cols_lim;
  logic [RCMP_W-1:0] rows_lim;
  logic              row_end, grid_end, accept, s1_go;
  size_t             ram_rdata, up, left, diag, min_ul, min3, size;

  always_comb begin
    if (grid_cols_r == '0) begin
      cols_lim = CCMP_W'(1);
    end else if (CCMP_W'(grid_cols_r) > CCMP_W'(MAX_COLS)) begin
      cols_lim = CCMP_W'(MAX_COLS);
    end else begin
      cols_lim = CCMP_W'(grid_cols_r);
    end
    if (grid_rows_r == '0) begin
      rows_lim = RCMP_W'(1);
    end else if (RCMP_W'(grid_rows_r) > RCMP_W'(MAX_ROWS)) begin
      rows_lim = RCMP_W'(MAX_ROWS);
    end else begin
      rows_lim = RCMP_W'(grid_rows_r);
    end
  end

  assign row_end  = (CCMP_W'(col_cnt_r) + CCMP_W'(1)) >= cols_lim;
  assign grid_end = row_end && ((RCMP_W'(row_cnt_r) + RCMP_W'(1)) >= rows_lim);

  assign s1_go    = s1_valid_r && !(s1_r.last && out_valid_r && out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !s1_go);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    s1_valid_nxt = s1_go ? 1'b0 : s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
      if (!row_end) begin
        col_cnt_nxt = col_cnt_r + COL_W'(1);
      end else begin
        col_cnt_nxt = '0;
        row_cnt_nxt = grid_end ? '0 : row_cnt_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= CFG_W'(1);
      grid_cols_r <= CFG_W'(1);
      obstacle_r  <= OBSTACLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows_r <= cfg_wdata;
        REG_GRID_COLS: grid_cols_r <= cfg_wdata;
        REG_OBSTACLE:  obstacle_r  <= cfg_wdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + COL_W'(1);
      if (clr_addr_r == COL_W'(MAX_COLS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.col       <= col_cnt_r;
      s1_r.row       <= row_cnt_r;
      s1_r.first_row <= (row_cnt_r == '0);
      s1_r.first_col <= (col_cnt_r == '0);
      s1_r.obst      <= (in_cell_char == obstacle_r);
      s1_r.last      <= grid_end;
      fwd_r          <= s1_go && (s1_r.col == col_cnt_r);
      fwd_data_r     <= size;
    end
  end

  lcsf_line_mem #(
    .DEPTH(MAX_COLS)
  ) u_line_mem (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (col_cnt_r),
    .rd_data_r(ram_rdata),
    .wr_en    (clearing_r || s1_go),
    .wr_addr  (clearing_r ? clr_addr_r : s1_r.col),
    .wr_data  (clearing_r ? '0 : size)
  );

  always_comb begin
    up     = s1_r.first_row ? '0 : (fwd_r ? fwd_data_r : ram_rdata);
    left   = s1_r.first_col ? '0 : left_r;
    diag   = (s1_r.first_col || s1_r.first_row) ? '0 : diag_r;
    min_ul = (up < left) ? up : left;
    min3   = (min_ul < diag) ? min_ul : diag;
    size   = s1_r.obst ? '0 : min3 + SIZE_W'(1);
    best_size_nxt = best_size_r;
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;
    if (size > best_size_r) begin
      best_size_nxt = size;
      best_row_nxt  = POS_W'(s1_r.row) + POS_W'(1) - POS_W'(size);
      best_col_nxt  = POS_W'(s1_r.col) + POS_W'(1) - POS_W'(size);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_go && s1_r.last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        if (s1_r.last) begin
          left_r      <= '0;
          diag_r      <= '0;
          best_size_r <= '0;
          best_row_r  <= '0;
          best_col_r  <= '0;
        end else begin
          left_r      <= size;
          diag_r      <= up;
          best_size_r <= best_size_nxt;
          best_row_r  <= best_row_nxt;
          best_col_r  <= best_col_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_r.last) begin
      out_size_r <= best_size_nxt;
      out_row_r  <= best_row_nxt;
      out_col_r  <= best_col_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_square_size = out_size_r;
  assign out_top_row     = out_row_r;
  assign out_left_col    = out_col_r;

  // The best square starts afresh once a grid's result has been loaded.
  a_best_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_r.last) |=> (best_size_r == '0))
    else $error("best square not cleared after grid end");

  // Within a grid the best size never shrinks.
  a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(s1_go) && !$past(s1_r.last)) |->
      (best_size_r >= $past(best_size_r)))
    else $error("best size decreased within a grid");

  // The clearing pass ends only after the last line store entry.
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(clearing_r)) |-> ($past(clr_addr_r) == COL_W'(MAX_COLS - 1)))
    else $error("clearing pass ended early");

  // A held result is never overwritten by the next grid.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(s1_go && s1_r.last))
    else $error("result overwritten while stalled");

endmodule

// ----- test/tb_largest_clear_square_finder.sv -----
module tb_largest_clear_square_finder;
  import lcsf_pkg::*;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int KEEP = -1;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_CELLS = 800;
  localparam longint TIMEOUT = 64'd10_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    size_t square_size;
    pos_t  top_row;
    pos_t  left_col;
  } square_t;

  typedef enum {FILL_CLEAR, FILL_BLOCKED, FILL_LAST_CLEAR, FILL_NOISE} fill_t;

  typedef struct {
    int          rows_w;
    int          cols_w;
    int          obst_w;
    bit          poke_unused;
    fill_t       fill;
    int unsigned cells;
    bit          fixed;
    square_t     want;
  } grid_case_t;

  // A cell count of zero means one whole grid at the current dimensions.
  grid_case_t grid_cases [16] = '{
    '{KEEP, KEEP, KEEP, 1'b0, FILL_CLEAR,      0, 1'b1, '{11'd1, 10'd0, 10'd0}},
    '{KEEP, KEEP, KEEP, 1'b0, FILL_BLOCKED,    0, 1'b1, '{11'd0, 10'd0, 10'd0}},
    '{0,    0,    0,    1'b0, FILL_CLEAR,      0, 1'b1, '{11'd1, 10'd0, 10'd0}},
    '{1,    128,  255,  1'b0, FILL_LAST_CLEAR, 0, 1'b1, '{11'd1, 10'd0, 10'd127}},
    '{128,  1,    0,    1'b0, FILL_LAST_CLEAR, 0, 1'b1, '{11'd1, 10'd127, 10'd0}},
    '{4,    4,    111,  1'b0, FILL_CLEAR,      0, 1'b1, '{11'd4, 10'd0, 10'd0}},
    '{1,    4,    KEEP, 1'b0, FILL_CLEAR,      0, 1'b1, '{11'd1, 10'd0, 10'd0}},
    '{3,    5,    KEEP, 1'b0, FILL_CLEAR,      0, 1'b1, '{11'd3, 10'd0, 10'd0}},
    '{5,    3,    KEEP, 1'b0, FILL_CLEAR,      0, 1'b1, '{11'd3, 10'd0, 10'd0}},
    '{6,    7,    KEEP, 1'b0, FILL_BLOCKED,    0, 1'b1, '{11'd0, 10'd0, 10'd0}},
    '{KEEP, KEEP, KEEP, 1'b0, FILL_NOISE,      0, 1'b0, '{11'd0, 10'd0, 10'd0}},
    '{2047, 2,    KEEP, 1'b0, FILL_CLEAR,      7, 1'b0, '{11'd0, 10'd0, 10'd0}},
    '{3,    KEEP, KEEP, 1'b0, FILL_CLEAR,      1, 1'b0, '{11'd0, 10'd0, 10'd0}},
    '{1,    2047, KEEP, 1'b0, FILL_NOISE,      5, 1'b0, '{11'd0, 10'd0, 10'd0}},
    '{KEEP, 3,    KEEP, 1'b0, FILL_NOISE,      1, 1'b0, '{11'd0, 10'd0, 10'd0}},
    '{2,    2,    KEEP, 1'b1, FILL_CLEAR,      0, 1'b1, '{11'd2, 10'd0, 10'd0}}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  char_t                in_cell_char;
  logic                 out_valid;
  logic                 out_stall;
  size_t                out_square_size;
  pos_t                 out_top_row;
  pos_t                 out_left_col;

  square_t     pending_squares[$];
  int          mismatch_count = 0;
  int unsigned tx_gap_max = 0;
  int unsigned rx_gap_max = 0;
  bit          hold_req = 1'b0;
  bit          use_typed = 1'b0;
  square_t     typed_result;

  int unsigned grid_rows_reg;
  int unsigned grid_cols_reg;
  char_t       obstacle_reg;
  int unsigned line_sizes [MAX_COLS];
  int unsigned left_sz;
  int unsigned diag_sz;
  int unsigned row_pos;
  int unsigned col_pos;
  int unsigned best_sz;
  int unsigned best_r;
  int unsigned best_c;

  largest_clear_square_finder #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cell_char   (in_cell_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_square_size(out_square_size),
    .out_top_row    (out_top_row),
    .out_left_col   (out_left_col)
  );

  always #10 clk = ~clk;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the line store by one cell; returns 1 when the cell closes a grid.
  function automatic bit scan_cell(input char_t c, output square_t res);
    int unsigned nrows, ncols, col, idx, up, lft, dg, sz;
    res = '0;
    nrows = clamp_dim(grid_rows_reg, MAX_ROWS);
    ncols = clamp_dim(grid_cols_reg, MAX_COLS);
    col = col_pos;
    idx = (col < MAX_COLS) ? col : MAX_COLS - 1;
    up = (row_pos == 0) ? 0 : line_sizes[idx];
    lft = (col == 0) ? 0 : left_sz;
    dg = (col == 0 || row_pos == 0) ? 0 : diag_sz;
    if (c == obstacle_reg) begin
      sz = 0;
    end else begin
      sz = (up < lft) ? up : lft;
      if (dg < sz) sz = dg;
      sz = (sz + 1) & 32'h7FF;
    end
    if (sz > best_sz) begin
      best_sz = sz;
      best_r = row_pos + 1 - sz;
      best_c = col + 1 - sz;
    end
    diag_sz = up;
    left_sz = sz;
    line_sizes[idx] = sz;
    if (col_pos + 1 < ncols) begin
      col_pos++;
      return 1'b0;
    end
    col_pos = 0;
    if (row_pos + 1 < nrows) begin
      row_pos++;
      return 1'b0;
    end
    res.square_size = size_t'(best_sz);
    res.top_row = pos_t'(best_r);
    res.left_col = pos_t'(best_c);
    left_sz = 0;
    diag_sz = 0;
    row_pos = 0;
    best_sz = 0;
    best_r = 0;
    best_c = 0;
    return 1'b1;
  endfunction

  function automatic char_t pick_cell(input int unsigned pct);
    char_t c;
    if ($urandom_range(99, 0) < pct) return obstacle_reg;
    c = char_t'($urandom_range(255, 0));
    if (c == obstacle_reg) c = ~c;
    return c;
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(9, 0))
      0: return 0;
      1: return $urandom_range(24, 7);
      default: return $urandom_range(6, 1);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    case (idx)
      REG_GRID_ROWS: grid_rows_reg = val & 32'h7FF;
      REG_GRID_COLS: grid_cols_reg = val & 32'h7FF;
      REG_OBSTACLE: obstacle_reg = char_t'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_cell(input char_t c);
    int unsigned gap;
    square_t res;
    gap = $urandom_range(tx_gap_max, 0);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_cell_char <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (scan_cell(c, res)) begin
      pending_squares.push_back(use_typed ? typed_result : res);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    square_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_squares.size() == 0) begin
        $error("result word with no square expected");
        mismatch_count++;
      end else begin
        want = pending_squares.pop_front();
        if (out_square_size !== want.square_size) begin
          $error("square_size: expected %0d, got %0d", want.square_size, out_square_size);
          mismatch_count++;
        end
        if (out_top_row !== want.top_row) begin
          $error("top_row: expected %0d, got %0d", want.top_row, out_top_row);
          mismatch_count++;
        end
        if (out_left_col !== want.left_col) begin
          $error("left_col: expected %0d, got %0d", want.left_col, out_left_col);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned pause;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      pause = $urandom_range(rx_gap_max, 0);
      if (hold_req) begin
        pause = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      repeat (pause) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("tb_largest_clear_square_finder: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned n, pct, rand_cells;
    char_t c;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cell_char = '0;
    grid_rows_reg = 1;
    grid_cols_reg = 1;
    obstacle_reg = OBSTACLE_RESET;
    foreach (line_sizes[i]) line_sizes[i] = 0;
    left_sz = 0;
    diag_sz = 0;
    row_pos = 0;
    col_pos = 0;
    best_sz = 0;
    best_r = 0;
    best_c = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (grid_cases[k]) begin
      tx_gap_max = $urandom_range(1, 0) ? 19 : 0;
      rx_gap_max = $urandom_range(1, 0) ? 19 : 0;
      if (grid_cases[k].rows_w != KEEP) write_reg(REG_GRID_ROWS, grid_cases[k].rows_w);
      if (grid_cases[k].cols_w != KEEP) write_reg(REG_GRID_COLS, grid_cases[k].cols_w);
      if (grid_cases[k].obst_w != KEEP) write_reg(REG_OBSTACLE, grid_cases[k].obst_w);
      if (grid_cases[k].poke_unused) write_reg(REG_UNUSED, 32'h7FF);
      n = grid_cases[k].cells;
      if (n == 0) n = clamp_dim(grid_rows_reg, MAX_ROWS) * clamp_dim(grid_cols_reg, MAX_COLS);
      use_typed = grid_cases[k].fixed;
      typed_result = grid_cases[k].want;
      for (int i = 0; i < n; i++) begin
        case (grid_cases[k].fill)
          FILL_CLEAR: c = pick_cell(0);
          FILL_BLOCKED: c = pick_cell(100);
          FILL_LAST_CLEAR: c = pick_cell((i == n - 1) ? 0 : 100);
          default: c = pick_cell(25);
        endcase
        send_cell(c);
      end
      settle();
    end
    use_typed = 1'b0;

    // The sink holds off while tiny grids stream in back to back, so the block backs up.
    write_reg(REG_GRID_ROWS, 1);
    write_reg(REG_GRID_COLS, 2);
    tx_gap_max = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 120; i++) send_cell(pick_cell(30));
    settle();

    rand_cells = 0;
    while (rand_cells < RANDOM_CELLS) begin
      tx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 19;
      rx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 19;
      if ($urandom_range(2, 0) != 0) write_reg(REG_GRID_ROWS, pick_dim());
      if ($urandom_range(2, 0) != 0) write_reg(REG_GRID_COLS, pick_dim());
      if ($urandom_range(3, 0) == 0) write_reg(REG_OBSTACLE, $urandom_range(255, 0));
      if ($urandom_range(15, 0) == 0) write_reg(REG_UNUSED, $urandom_range(2047, 0));
      case ($urandom_range(3, 0))
        0: pct = 0;
        1: pct = 10;
        2: pct = 30;
        default: pct = 60;
      endcase
      n = clamp_dim(grid_rows_reg, MAX_ROWS) * clamp_dim(grid_cols_reg, MAX_COLS)
          * $urandom_range(3, 1);
      // Now and then the phase stops part-way through a grid.
      if ($urandom_range(4, 0) == 0) n = $urandom_range(n, 1);
      for (int i = 0; i < n; i++) send_cell(pick_cell(pct));
      rand_cells += n;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("tb_largest_clear_square_finder: done, clean");
    end else begin
      $display("tb_largest_clear_square_finder: done, errors");
    end
    $finish;
  end

endmodule
